// ===== hw/rtl/dht_pkg.sv =====
`timescale 1ns / 1ps

package dht_pkg;

    // Result status codes.
    localparam logic [2:0] ST_INSERTED  = 3'd0;
    localparam logic [2:0] ST_FOUND     = 3'd1;
    localparam logic [2:0] ST_NOT_FOUND = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_ZERO_KEY  = 3'd4;

    localparam int KeyW   = 31;
    localparam int SlotW  = 8;
    localparam int PcW    = 4;

    // Datapath operation selected by a control word.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_MOD_STEP,
        OP_PROBE_INIT,
        OP_PROBE_NEXT,
        OP_SCAN_INIT,
        OP_SCAN_NEXT,
        OP_EMIT_INSERTED,
        OP_EMIT_FOUND,
        OP_EMIT_NOT_FOUND,
        OP_EMIT_FULL,
        OP_EMIT_ZERO
    } op_t;

    // Jump condition selected by a control word.
    typedef enum logic [3:0] {
        COND_NEVER,
        COND_NO_INPUT,
        COND_KEY_ZERO,
        COND_SEARCH,
        COND_EMPTY,
        COND_PROBE_MORE,
        COND_MATCH,
        COND_SCAN_MORE,
        COND_OUT_BUSY
    } cond_t;

    typedef struct packed {
        op_t            op;
        cond_t          cond;
        logic [PcW-1:0] target;
        logic           ret;
    } ctl_word_t;

    // Program addresses.
    localparam logic [PcW-1:0] P_IDLE       = 4'd0;
    localparam logic [PcW-1:0] P_CHECK      = 4'd1;
    localparam logic [PcW-1:0] P_BRANCH     = 4'd2;
    localparam logic [PcW-1:0] P_MOD        = 4'd3;
    localparam logic [PcW-1:0] P_PROBE_INIT = 4'd4;
    localparam logic [PcW-1:0] P_PROBE_TEST = 4'd5;
    localparam logic [PcW-1:0] P_PROBE_NEXT = 4'd6;
    localparam logic [PcW-1:0] P_FULL       = 4'd7;
    localparam logic [PcW-1:0] P_STORE      = 4'd8;
    localparam logic [PcW-1:0] P_SCAN_INIT  = 4'd9;
    localparam logic [PcW-1:0] P_SCAN_READ  = 4'd10;
    localparam logic [PcW-1:0] P_SCAN_TEST  = 4'd11;
    localparam logic [PcW-1:0] P_SCAN_NEXT  = 4'd12;
    localparam logic [PcW-1:0] P_NOT_FOUND  = 4'd13;
    localparam logic [PcW-1:0] P_FOUND      = 4'd14;
    localparam logic [PcW-1:0] P_ZERO       = 4'd15;

    // The microprogram. A taken jump goes to target; otherwise the step
    // counter moves on, or returns to idle when ret is set.
    function automatic ctl_word_t dht_rom(input logic [PcW-1:0] pc);
        ctl_word_t w;
        w = '{op: OP_NONE, cond: COND_NEVER, target: P_IDLE, ret: 1'b1};
        unique case (pc)
            P_IDLE:       w = '{OP_ACCEPT,         COND_NO_INPUT,   P_IDLE,       1'b0};
            P_CHECK:      w = '{OP_NONE,           COND_KEY_ZERO,   P_ZERO,       1'b0};
            P_BRANCH:     w = '{OP_NONE,           COND_SEARCH,     P_SCAN_INIT,  1'b0};
            P_MOD:        w = '{OP_MOD_STEP,       COND_NEVER,      P_IDLE,       1'b0};
            P_PROBE_INIT: w = '{OP_PROBE_INIT,     COND_NEVER,      P_IDLE,       1'b0};
            P_PROBE_TEST: w = '{OP_NONE,           COND_EMPTY,      P_STORE,      1'b0};
            P_PROBE_NEXT: w = '{OP_PROBE_NEXT,     COND_PROBE_MORE, P_PROBE_TEST, 1'b0};
            P_FULL:       w = '{OP_EMIT_FULL,      COND_OUT_BUSY,   P_FULL,       1'b1};
            P_STORE:      w = '{OP_EMIT_INSERTED,  COND_OUT_BUSY,   P_STORE,      1'b1};
            P_SCAN_INIT:  w = '{OP_SCAN_INIT,      COND_NEVER,      P_IDLE,       1'b0};
            P_SCAN_READ:  w = '{OP_NONE,           COND_NEVER,      P_IDLE,       1'b0};
            P_SCAN_TEST:  w = '{OP_NONE,           COND_MATCH,      P_FOUND,      1'b0};
            P_SCAN_NEXT:  w = '{OP_SCAN_NEXT,      COND_SCAN_MORE,  P_SCAN_READ,  1'b0};
            P_NOT_FOUND:  w = '{OP_EMIT_NOT_FOUND, COND_OUT_BUSY,   P_NOT_FOUND,  1'b1};
            P_FOUND:      w = '{OP_EMIT_FOUND,     COND_OUT_BUSY,   P_FOUND,      1'b1};
            P_ZERO:       w = '{OP_EMIT_ZERO,      COND_OUT_BUSY,   P_ZERO,       1'b1};
            default:      w = '{OP_NONE,           COND_NEVER,      P_IDLE,       1'b1};
        endcase
        return w;
    endfunction

endpackage

// ===== hw/rtl/dht_req_if.sv =====
`timescale 1ns / 1ps

// Request channel: one item is a mode and a key.
interface dht_req_if
    import dht_pkg::*;
();
    logic            valid;
    logic            ready;
    logic            mode;
    logic [KeyW-1:0] key;

    modport source (output valid, output mode, output key, input ready);
    modport sink   (input valid, input mode, input key, output ready);
endinterface

// ===== hw/rtl/dht_rsp_if.sv =====
`timescale 1ns / 1ps

// Response channel: one item is a slot index and a status code.
interface dht_rsp_if
    import dht_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [SlotW-1:0] slot_index;
    logic [2:0]       status;

    modport source (output valid, output slot_index, output status, input ready);
    modport sink   (input valid, input slot_index, input status, output ready);
endinterface

// ===== hw/rtl/double_hash_table_insert_search_unit.sv =====
// Open-addressing hash table of TABLE_SIZE keys with double hashing. Each
// request item carries a mode (0 insert, 1 search) and a 31-bit key; each
// request gives exactly one response item with a slot index and a status
// (0 inserted, 1 found, 2 not found, 3 table full, 4 key zero rejected). The
// table is empty after reset with no clearing pass. Items are handled one at
// a time by a small microprogram. An insert first divides the key by
// TABLE_SIZE and TABLE_SIZE-1 with reciprocal multipliers, and then tests
// one probe slot at a time until it finds an empty one or has tried
// TABLE_SIZE probes, when it reports the table full. A search scans the key
// memory from slot 0 through its single registered read port, one slot at a
// time, and reports not found when no slot holds the key. A finished
// response waits in an output register, and the next request is taken
// meanwhile.
`timescale 1ns / 1ps

module double_hash_table_insert_search_unit
    import dht_pkg::*;
#(
    parameter int TABLE_SIZE = 7
) (
    input  logic      clk,
    input  logic      rst_n,
    dht_req_if.sink   request,
    dht_rsp_if.source response
);

    localparam int IW = $clog2(TABLE_SIZE);

    // Rounded-up reciprocals: (key * RCP) >> KSH is the exact quotient for
    // every 31-bit key.
    localparam int KSH_M = KeyW + IW;
    localparam int KSH_N = KeyW + $clog2(TABLE_SIZE - 1);
    localparam logic [63:0] RCP_M_W =
        ((64'd1 << KSH_M) + 64'(TABLE_SIZE - 1)) / 64'(TABLE_SIZE);
    localparam logic [63:0] RCP_N_W =
        ((64'd1 << KSH_N) + 64'(TABLE_SIZE - 2)) / 64'(TABLE_SIZE - 1);
    localparam logic [KeyW:0] RCP_M = RCP_M_W[KeyW:0];
    localparam logic [KeyW:0] RCP_N = RCP_N_W[KeyW:0];

    localparam logic [IW:0]   SIZE_W   = (IW + 1)'(TABLE_SIZE);
    localparam logic [IW-1:0] SIZE_LO  = IW'(TABLE_SIZE);
    localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_SIZE - 1);

    // Sequencer.
    logic [PcW-1:0] pc_reg, pc_next;
    ctl_word_t      ctl;
    logic           cond_hit;
    logic           out_free;

    // Control registers.
    logic                  rsp_valid_reg, rsp_valid_next;
    logic [TABLE_SIZE-1:0] occ_reg, occ_next;

    // Datapath registers.
    logic              mode_reg, mode_next;
    logic [KeyW-1:0]   key_reg, key_next;
    logic [IW-1:0]     quot_m_reg, quot_m_next;
    logic [IW-1:0]     quot_n_reg, quot_n_next;
    logic [IW-1:0]     probe_reg, probe_next;
    logic [IW-1:0]     stride_reg, stride_next;
    logic [IW-1:0]     probe_cnt_reg, probe_cnt_next;
    logic [IW-1:0]     scan_reg, scan_next;
    logic [SlotW-1:0]  slot_reg, slot_next;
    logic [2:0]        status_reg, status_next;

    // Key memory with a registered read port addressed by the scan index.
    logic [KeyW-1:0] key_mem [TABLE_SIZE];
    logic [KeyW-1:0] rd_key_reg;
    logic            rd_occ_reg;
    logic            mem_we;

    logic [2*KeyW:0]     prod_m;
    logic [2*KeyW:0]     prod_n;
    logic [IW-1:0]       rem_m;
    logic [IW-1:0]       rem_n;
    logic [IW:0]         first_sum;
    logic [IW:0]         probe_sum;

    assign ctl      = dht_rom(pc_reg);
    assign out_free = !rsp_valid_reg || response.ready;

    assign request.ready       = (ctl.op == OP_ACCEPT);
    assign response.valid      = rsp_valid_reg;
    assign response.slot_index = slot_reg;
    assign response.status     = status_reg;

    // Jump condition.
    always_comb
    begin
        unique case (ctl.cond)
            COND_NEVER:      cond_hit = 1'b0;
            COND_NO_INPUT:   cond_hit = !request.valid;
            COND_KEY_ZERO:   cond_hit = (key_reg == '0);
            COND_SEARCH:     cond_hit = mode_reg;
            COND_EMPTY:      cond_hit = !occ_reg[probe_reg];
            COND_PROBE_MORE: cond_hit = (probe_cnt_reg != LAST_IDX);
            COND_MATCH:      cond_hit = rd_occ_reg && (rd_key_reg == key_reg);
            COND_SCAN_MORE:  cond_hit = (scan_reg != LAST_IDX);
            COND_OUT_BUSY:   cond_hit = !out_free;
            default:         cond_hit = 1'b0;
        endcase
    end

    always_comb
    begin
        if (cond_hit) begin
            pc_next = ctl.target;
        end else if (ctl.ret) begin
            pc_next = P_IDLE;
        end else begin
            pc_next = pc_reg + 1'b1;
        end
    end

    // Quotients by reciprocal multiplication. Only the low quotient bits are
    // kept, since a remainder below TABLE_SIZE follows from the low bits of
    // key - quotient * divisor alone.
    assign prod_m = {{(KeyW + 1){1'b0}}, key_reg} * {{KeyW{1'b0}}, RCP_M};
    assign prod_n = {{(KeyW + 1){1'b0}}, key_reg} * {{KeyW{1'b0}}, RCP_N};
    assign rem_m  = key_reg[IW-1:0] - quot_m_reg * SIZE_LO;
    assign rem_n  = key_reg[IW-1:0] - quot_n_reg * LAST_IDX;

    assign first_sum = {1'b0, rem_m} + 1'b1;
    assign probe_sum = {1'b0, probe_reg} + {1'b0, stride_reg};

    // Datapath: each operation of the control word.
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        occ_next       = occ_reg;
        mode_next      = mode_reg;
        key_next       = key_reg;
        quot_m_next    = quot_m_reg;
        quot_n_next    = quot_n_reg;
        probe_next     = probe_reg;
        stride_next    = stride_reg;
        probe_cnt_next = probe_cnt_reg;
        scan_next      = scan_reg;
        slot_next      = slot_reg;
        status_next    = status_reg;
        mem_we         = 1'b0;

        if (rsp_valid_reg && response.ready) begin
            rsp_valid_next = 1'b0;
        end

        case (ctl.op)
            OP_ACCEPT:
            begin
                if (request.valid) begin
                    mode_next = request.mode;
                    key_next  = request.key;
                end
            end
            OP_MOD_STEP:
            begin
                quot_m_next = prod_m[KSH_M +: IW];
                quot_n_next = prod_n[KSH_N +: IW];
            end
            OP_PROBE_INIT:
            begin
                probe_next     = (first_sum == SIZE_W) ? '0 : first_sum[IW-1:0];
                stride_next    = LAST_IDX - rem_n;
                probe_cnt_next = '0;
            end
            OP_PROBE_NEXT:
            begin
                probe_next     = (probe_sum >= SIZE_W) ? IW'(probe_sum - SIZE_W)
                                                       : probe_sum[IW-1:0];
                probe_cnt_next = probe_cnt_reg + 1'b1;
            end
            OP_SCAN_INIT:
            begin
                scan_next = '0;
            end
            OP_SCAN_NEXT:
            begin
                scan_next = scan_reg + 1'b1;
            end
            OP_EMIT_INSERTED:
            begin
                if (out_free) begin
                    mem_we              = 1'b1;
                    occ_next[probe_reg] = 1'b1;
                    slot_next           = SlotW'(probe_reg);
                    status_next         = ST_INSERTED;
                    rsp_valid_next      = 1'b1;
                end
            end
            OP_EMIT_FOUND:
            begin
                if (out_free) begin
                    slot_next      = SlotW'(scan_reg);
                    status_next    = ST_FOUND;
                    rsp_valid_next = 1'b1;
                end
            end
            OP_EMIT_NOT_FOUND:
            begin
                if (out_free) begin
                    slot_next      = '0;
                    status_next    = ST_NOT_FOUND;
                    rsp_valid_next = 1'b1;
                end
            end
            OP_EMIT_FULL:
            begin
                if (out_free) begin
                    slot_next      = '0;
                    status_next    = ST_FULL;
                    rsp_valid_next = 1'b1;
                end
            end
            OP_EMIT_ZERO:
            begin
                if (out_free) begin
                    slot_next      = '0;
                    status_next    = ST_ZERO_KEY;
                    rsp_valid_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control state: step counter, response flag and slot occupancy.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pc_reg        <= P_IDLE;
            rsp_valid_reg <= 1'b0;
            occ_reg       <= '0;
        end else begin
            pc_reg        <= pc_next;
            rsp_valid_reg <= rsp_valid_next;
            occ_reg       <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg      <= mode_next;
        key_reg       <= key_next;
        quot_m_reg    <= quot_m_next;
        quot_n_reg    <= quot_n_next;
        probe_reg     <= probe_next;
        stride_reg    <= stride_next;
        probe_cnt_reg <= probe_cnt_next;
        scan_reg      <= scan_next;
        slot_reg      <= slot_next;
        status_reg    <= status_next;
    end

    // Key memory. An entry whose occupancy bit is clear reads as empty.
    always_ff @(posedge clk)
    begin
        if (mem_we) begin
            key_mem[probe_reg] <= key_reg;
        end
        rd_key_reg <= key_mem[scan_reg];
        rd_occ_reg <= occ_reg[scan_reg];
    end

endmodule
